[sv/sat_pkg.sv]
// ============================================================================
// Segment address translator package
// Shared types, constants and codes for the segment address translator.
// ============================================================================
package sat_pkg;

    // Table geometry.
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int SCAN_BITS = $clog2(NUM_SLOTS + 1);

    // Field widths.
    localparam int ADDR_W = 32;
    localparam int ID_W   = 16;
    localparam int ASZ_W  = 16;

    // Reset value of the maximum segment size register.
    localparam logic [ADDR_W-1:0] MAX_SEG_RESET = ADDR_W'(64);

    // Divider step count, one quotient bit per step.
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        CMD_WRITE     = 1'b0,
        CMD_TRANSLATE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SEGMENT = 2'd1,
        ST_BEYOND_END = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_DIVIDE,
        FSM_SEARCH,
        FSM_CHECK,
        FSM_FINISH
    } fsm_state_t;

    // One input item.
    typedef struct packed {
        cmd_t              command;
        logic [3:0]        entry_slot;
        logic              entry_valid;
        logic [ID_W-1:0]   entry_id;
        logic [ADDR_W-1:0] entry_base;
        logic [ADDR_W-1:0] entry_size;
        logic [ADDR_W-1:0] logical_address;
        logic [ASZ_W-1:0]  access_size;
    } in_item_t;

    // One result item.
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] physical_address;
        logic [ADDR_W-1:0] segment_number;
        logic [ADDR_W-1:0] segment_offset;
    } out_item_t;

    // One segment table entry as held in the table memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
    } entry_t;

endpackage

[sv/segment_address_translator.sv]
// ============================================================================
// Segment address translator
// Segmentation MMU: segment table writes and logical address translation.
// ============================================================================
// The block takes one transfer at a time. A table write is stored as it is
// taken and then reported. A translation splits the address with a
// one-bit-per-cycle divider, then scans the table memory one slot per cycle
// through its single read port, stopping at the first valid match, then
// does the bounds check; a segment number wider than 16 bits skips the scan.
// The next input transfer is taken once the result sits in the output
// register, even while that result is still stalled. The maximum segment
// size register may be written only while the block is idle.
module segment_address_translator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [sat_pkg::ADDR_W-1:0] cfg_write_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  sat_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output sat_pkg::out_item_t         out_data
);

    sat_pkg::fsm_state_t            state_reg;
    sat_pkg::fsm_state_t            state_next;
    logic [sat_pkg::ADDR_W-1:0]     max_seg_reg;
    logic [sat_pkg::NUM_SLOTS-1:0]  slot_valid_reg;
    sat_pkg::in_item_t              item_reg;
    logic [sat_pkg::SCAN_BITS-1:0]  scan_reg;
    logic                           pending_reg;
    logic [sat_pkg::SLOT_BITS-1:0]  cmp_slot_reg;
    logic [sat_pkg::ADDR_W-1:0]     base_reg;
    logic [sat_pkg::ADDR_W-1:0]     size_reg;
    sat_pkg::status_t               status_reg;
    sat_pkg::status_t               status_next;
    logic [sat_pkg::ADDR_W-1:0]     phys_reg;
    logic [sat_pkg::ADDR_W-1:0]     phys_next;
    logic                           out_valid_reg;
    sat_pkg::out_item_t             out_data_reg;
    sat_pkg::out_item_t             out_data_next;

    logic                           accept;
    logic                           ram_we;
    logic                           div_start;
    logic                           div_done;
    logic [sat_pkg::ADDR_W-1:0]     quotient;
    logic [sat_pkg::ADDR_W-1:0]     remainder;
    sat_pkg::entry_t                ram_wdata;
    sat_pkg::entry_t                ram_rdata;
    logic                           issue;
    logic                           hit;
    logic                           miss;
    logic                           out_load;
    logic [sat_pkg::ADDR_W:0]       span;
    logic                           beyond;

    // Input transfer.
    assign in_stall = (state_reg != sat_pkg::FSM_IDLE);
    assign accept   = in_valid && !in_stall;

    // Segment table memory.
    assign ram_wdata.id   = in_data.entry_id;
    assign ram_wdata.base = in_data.entry_base;
    assign ram_wdata.size = in_data.entry_size;

    sat_table_ram u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (sat_pkg::SLOT_BITS'(in_data.entry_slot)),
        .wr_data (ram_wdata),
        .rd_addr (scan_reg[sat_pkg::SLOT_BITS-1:0]),
        .rd_data (ram_rdata)
    );

    // Address splitter.
    sat_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (in_data.logical_address),
        .divisor   (max_seg_reg),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Scan compare. The memory and the valid bits change only on an accepted
    // write in idle, so the scan never overlaps a write to the same slot.
    always_comb
    begin
        issue = (scan_reg < sat_pkg::SCAN_BITS'(sat_pkg::NUM_SLOTS));
        hit   = pending_reg && slot_valid_reg[cmp_slot_reg]
                && (ram_rdata.id == quotient[sat_pkg::ID_W-1:0])
                && (quotient[sat_pkg::ADDR_W-1:sat_pkg::ID_W] == '0);
        miss  = (quotient[sat_pkg::ADDR_W-1:sat_pkg::ID_W] != '0)
                || (!pending_reg && !issue);
    end

    // Bounds check at 33 bits.
    always_comb
    begin
        span   = {1'b0, remainder} + (sat_pkg::ADDR_W + 1)'(item_reg.access_size);
        beyond = (span > {1'b0, size_reg});
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sat_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.command == sat_pkg::CMD_TRANSLATE)
                    begin
                        state_next = sat_pkg::FSM_DIVIDE;
                    end
                    else
                    begin
                        state_next = sat_pkg::FSM_FINISH;
                    end
                end
            end
            sat_pkg::FSM_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = sat_pkg::FSM_SEARCH;
                end
            end
            sat_pkg::FSM_SEARCH:
            begin
                if (hit)
                begin
                    state_next = sat_pkg::FSM_CHECK;
                end
                else if (miss)
                begin
                    state_next = sat_pkg::FSM_FINISH;
                end
            end
            sat_pkg::FSM_CHECK:
            begin
                state_next = sat_pkg::FSM_FINISH;
            end
            sat_pkg::FSM_FINISH:
            begin
                if (out_load)
                begin
                    state_next = sat_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = sat_pkg::FSM_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        ram_we      = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        status_next = status_reg;
        phys_next   = phys_reg;
        case (state_reg)
            sat_pkg::FSM_IDLE:
            begin
                if (accept && in_data.command == sat_pkg::CMD_WRITE)
                begin
                    ram_we = (int'(in_data.entry_slot) < sat_pkg::NUM_SLOTS);
                end
                div_start   = accept && (in_data.command == sat_pkg::CMD_TRANSLATE);
                status_next = sat_pkg::ST_OK;
                phys_next   = '0;
            end
            sat_pkg::FSM_SEARCH:
            begin
                if (!hit && miss)
                begin
                    status_next = sat_pkg::ST_NO_SEGMENT;
                end
            end
            sat_pkg::FSM_CHECK:
            begin
                if (beyond)
                begin
                    status_next = sat_pkg::ST_BEYOND_END;
                end
                else
                begin
                    phys_next = base_reg + remainder;
                end
            end
            sat_pkg::FSM_FINISH:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Result assembly; a table write reports zeros.
    always_comb
    begin
        out_data_next.status           = status_reg;
        out_data_next.physical_address = phys_reg;
        out_data_next.segment_number   = quotient;
        out_data_next.segment_offset   = remainder;
        if (item_reg.command == sat_pkg::CMD_WRITE)
        begin
            out_data_next.status           = sat_pkg::ST_OK;
            out_data_next.physical_address = '0;
            out_data_next.segment_number   = '0;
            out_data_next.segment_offset   = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sat_pkg::FSM_IDLE;
            max_seg_reg    <= sat_pkg::MAX_SEG_RESET;
            slot_valid_reg <= '0;
            scan_reg       <= '0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                max_seg_reg <= cfg_write_data;
            end
            if (ram_we)
            begin
                slot_valid_reg[sat_pkg::SLOT_BITS'(in_data.entry_slot)] <=
                    in_data.entry_valid;
            end
            // Scan address and read-pending flag.
            if (state_reg == sat_pkg::FSM_SEARCH)
            begin
                pending_reg <= issue;
                if (issue)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            else
            begin
                pending_reg <= 1'b0;
                scan_reg    <= '0;
            end
            // Output register.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (state_reg == sat_pkg::FSM_SEARCH)
        begin
            cmp_slot_reg <= scan_reg[sat_pkg::SLOT_BITS-1:0];
        end
        if (hit)
        begin
            base_reg <= ram_rdata.base;
            size_reg <= ram_rdata.size;
        end
        status_reg <= status_next;
        phys_reg   <= phys_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An accepted item keeps the input side stalled on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after a transfer");

    // A fault never carries a physical address.
    a_fault_zero_phys: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != sat_pkg::ST_OK)
        |-> (out_data.physical_address == '0))
        else $error("faulted result carries an address");

    // The divider finishes only while the controller waits for it.
    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == sat_pkg::FSM_DIVIDE))
        else $error("divider finished outside the divide state");

    // Table writes happen only from idle, never during a scan.
    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == sat_pkg::FSM_IDLE))
        else $error("table written while busy");

endmodule

[sv/sat_divider.sv]
// ============================================================================
// Segment address translator divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ============================================================================
module sat_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sat_pkg::ADDR_W-1:0] dividend,
    input  logic [sat_pkg::ADDR_W-1:0] divisor,
    output logic                       done,
    output logic [sat_pkg::ADDR_W-1:0] quotient,
    output logic [sat_pkg::ADDR_W-1:0] remainder
);

    logic [sat_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [sat_pkg::ADDR_W-1:0]    quo_reg;
    logic [sat_pkg::ADDR_W-1:0]    rem_reg;
    logic [sat_pkg::ADDR_W-1:0]    dsr_reg;
    logic [sat_pkg::ADDR_W:0]      trial;
    logic                          take;

    // Trial subtraction of the shifted partial remainder. A zero divisor
    // always subtracts, which leaves all ones and the dividend as remainder.
    always_comb
    begin
        trial = {rem_reg, quo_reg[sat_pkg::ADDR_W-1]};
        take  = (trial >= {1'b0, dsr_reg});
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= sat_pkg::DIV_CNT_W'(sat_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Quotient and remainder shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[sat_pkg::ADDR_W-2:0], take};
            if (take)
            begin
                rem_reg <= sat_pkg::ADDR_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= trial[sat_pkg::ADDR_W-1:0];
            end
        end
    end

    // The final step completes at the edge where done is high.
    assign done      = (cnt_reg == sat_pkg::DIV_CNT_W'(1));
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[sv/sat_table_ram.sv]
// ============================================================================
// Segment address translator table memory
// Single-port-write, single-port-read memory of segment entries.
// ============================================================================
module sat_table_ram (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [sat_pkg::SLOT_BITS-1:0] wr_addr,
    input  sat_pkg::entry_t               wr_data,
    input  logic [sat_pkg::SLOT_BITS-1:0] rd_addr,
    output sat_pkg::entry_t               rd_data
);

    sat_pkg::entry_t mem [sat_pkg::NUM_SLOTS];
    sat_pkg::entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
